// ----- sv/cc20sc_pkg.sv -----
`default_nettype none

package cc20sc_pkg;

   // block geometry
   localparam int WORDS       = 16;
   localparam int WORD_W      = 32;
   localparam int POS_W       = 6;
   localparam int DOUBLE_RNDS = 10;
   // two quarter-round halves per round, column and diagonal round per double round
   localparam int ROUND_STEPS = 4 * DOUBLE_RNDS;
   localparam int STEP_W      = $clog2(ROUND_STEPS);

   localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART0       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART1       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART2       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART3       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_LOW       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_HIGH      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_COUNTER = 3'd6;

   typedef logic [WORDS-1:0][WORD_W-1:0] block_type;

   typedef struct packed {
      logic [7:0][WORD_W-1:0] key;
      logic [2:0][WORD_W-1:0] nonce;
   } cipher_cfg_type;

   // one byte on its way from front to back
   typedef struct packed {
      logic [7:0]        data;
      logic [POS_W-1:0]  pos;
      logic              new_block;
      logic [WORD_W-1:0] counter;
   } queue_item_type;

   typedef struct packed {
      logic              start;
      logic              abort;
      logic [WORD_W-1:0] counter;
   } engine_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [WORD_W-1:0] tag;
   } engine_status_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] tag;
      block_type         words;
   } engine_result_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_ROUND,
      ENG_FINAL
   } engine_state_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

endpackage

`default_nettype wire

// ----- sv/cc20sc_front.sv -----
`default_nettype none

module cc20sc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_message_start,
   input  wire logic [cc20sc_pkg::WORD_W-1:0]  initial_counter,
   input  wire logic                           full,
   output logic                                push,
   output cc20sc_pkg::queue_item_type          item
);
   import cc20sc_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] ctr_ff, ctr_in;
   logic [POS_W-1:0]  beat_pos;
   logic [WORD_W-1:0] beat_ctr;
   logic              beat_new;

   // classify the beat: its place in the block and the block it needs
   always_comb begin
      beat_pos = req_message_start ? '0 : pos_ff;
      beat_ctr = req_message_start ? initial_counter : ctr_ff;
      beat_new = (beat_pos == '0);
      push     = req_valid && !full;

      item.data      = req_data_byte;
      item.pos       = beat_pos;
      item.new_block = beat_new;
      item.counter   = beat_ctr;

      pos_in = pos_ff;
      ctr_in = ctr_ff;
      if (push) begin
         pos_in = beat_pos + POS_W'(1);
         ctr_in = beat_new ? beat_ctr + WORD_W'(1) : beat_ctr;
      end
   end

   // advance position and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ctr_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ctr_ff <= ctr_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cc20sc_queue.sv -----
`default_nettype none

module cc20sc_queue #(
   parameter int DEPTH = cc20sc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire cc20sc_pkg::queue_item_type push_item,
   input  wire logic                      pop,
   output logic                           full,
   output logic                           head_valid,
   output cc20sc_pkg::queue_item_type     head_item
);
   import cc20sc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_item  = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // hold the beats
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more beats than its depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue pushed while full");

endmodule

`default_nettype wire

// ----- sv/cc20sc_engine.sv -----
`default_nettype none

module cc20sc_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cc20sc_pkg::cipher_cfg_type cfg,
   input  wire cc20sc_pkg::engine_cmd_type cmd,
   output cc20sc_pkg::engine_status_type status,
   output cc20sc_pkg::engine_result_type result
);
   import cc20sc_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);

   engine_state_type  state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] tag_ff, tag_in;
   block_type         x_ff, x_in;
   block_type         init_ff, init_in;
   block_type         x_round;
   block_type         start_block;
   logic              diag;
   logic              late_half;

   // lane results of one half quarter round
   logic [3:0][WORD_W-1:0] lane_a, lane_b, lane_c, lane_d;

   assign diag      = step_ff[1];
   assign late_half = step_ff[0];

   // build the starting block from constants, key, counter and nonce
   always_comb begin
      start_block[0]  = SIGMA0;
      start_block[1]  = SIGMA1;
      start_block[2]  = SIGMA2;
      start_block[3]  = SIGMA3;
      for (int k = 0; k < 8; k++) begin
         start_block[4 + k] = cfg.key[k];
      end
      start_block[12] = cmd.counter;
      start_block[13] = cfg.nonce[0];
      start_block[14] = cfg.nonce[1];
      start_block[15] = cfg.nonce[2];
   end

   // four quarter-round lanes, two add-xor-rotate steps each cycle
   for (genvar i = 0; i < 4; i++) begin : g_lane
      localparam int BC = 4 + i;
      localparam int BD = 4 + ((i + 1) % 4);
      localparam int CC = 8 + i;
      localparam int CD = 8 + ((i + 2) % 4);
      localparam int DC = 12 + i;
      localparam int DD = 12 + ((i + 3) % 4);

      logic [WORD_W-1:0] a0, b0, c0, d0, a1, d1, c1, b1, dx, bx;

      always_comb begin
         a0 = x_ff[i];
         b0 = diag ? x_ff[BD] : x_ff[BC];
         c0 = diag ? x_ff[CD] : x_ff[CC];
         d0 = diag ? x_ff[DD] : x_ff[DC];
         a1 = a0 + b0;
         dx = d0 ^ a1;
         d1 = late_half ? rotl(dx, 8) : rotl(dx, 16);
         c1 = c0 + d1;
         bx = b0 ^ c1;
         b1 = late_half ? rotl(bx, 7) : rotl(bx, 12);
         lane_a[i] = a1;
         lane_b[i] = b1;
         lane_c[i] = c1;
         lane_d[i] = d1;
      end
   end

   // put lane results back in their rows
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         x_round[j]      = lane_a[j];
         x_round[4 + j]  = diag ? lane_b[(j + 3) % 4] : lane_b[j];
         x_round[8 + j]  = diag ? lane_c[(j + 2) % 4] : lane_c[j];
         x_round[12 + j] = diag ? lane_d[(j + 1) % 4] : lane_d[j];
      end
   end

   // sequence load, rounds and feed-forward, and return to idle on abort
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      tag_in   = tag_ff;
      x_in     = x_ff;
      init_in  = init_ff;

      case (state_ff)
         ENG_IDLE: begin
            state_in = ENG_IDLE;
         end
         ENG_ROUND: begin
            x_in    = x_round;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ENG_FINAL;
            end
         end
         ENG_FINAL: begin
            state_in = ENG_IDLE;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase

      if (cmd.abort) begin
         state_in = ENG_IDLE;
      end else if (cmd.start) begin
         state_in = ENG_ROUND;
         step_in  = '0;
         tag_in   = cmd.counter;
         x_in     = start_block;
         init_in  = start_block;
      end

      status.busy  = (state_ff != ENG_IDLE);
      status.tag   = tag_ff;
      result.valid = (state_ff == ENG_FINAL) && !cmd.start && !cmd.abort;
      result.tag   = tag_ff;
      for (int w = 0; w < WORDS; w++) begin
         result.words[w] = x_ff[w] + init_ff[w];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      x_ff    <= x_in;
      init_ff <= init_in;
   end

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_ROUND && step_ff == LAST_STEP && !cmd.start && !cmd.abort)
      |=> state_ff == ENG_FINAL)
      else $error("round sequence did not end in feed-forward");

   a_round_step_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && !cmd.abort) |=> (state_ff == ENG_ROUND && step_ff == '0))
      else $error("block start did not restart the rounds");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> $past(state_ff) == ENG_ROUND || $past(cmd.start))
      else $error("block result without a round sequence");

endmodule

`default_nettype wire

// ----- sv/cc20sc_back.sv -----
`default_nettype none

module cc20sc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cfg_write,
   input  wire logic                      head_valid,
   input  wire cc20sc_pkg::queue_item_type    head_item,
   output logic                           pop,
   output cc20sc_pkg::engine_cmd_type     eng_cmd,
   input  wire cc20sc_pkg::engine_status_type eng_status,
   input  wire cc20sc_pkg::engine_result_type eng_result,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_out_byte
);
   import cc20sc_pkg::*;

   block_type         cur_words_ff, cur_words_in;
   block_type         next_words_ff, next_words_in;
   logic [WORD_W-1:0] next_tag_ff, next_tag_in;
   logic              next_valid_ff, next_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              out_free;
   logic              hit;
   logic              swap;
   logic              miss_start;
   block_type         src_words;
   logic [WORD_W-1:0] src_word;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      hit        = next_valid_ff && (next_tag_ff == head_item.counter);
      pop        = head_valid && out_free && (!head_item.new_block || hit);
      swap       = pop && head_item.new_block;
      miss_start = head_valid && head_item.new_block && !hit
                   && !(eng_status.busy && eng_status.tag == head_item.counter);

      // prefetch the following block on a swap, fetch the wanted one on a miss
      eng_cmd.abort   = cfg_write;
      eng_cmd.start   = swap || miss_start;
      eng_cmd.counter = swap ? head_item.counter + WORD_W'(1) : head_item.counter;

      // pick the keystream byte
      src_words   = head_item.new_block ? next_words_ff : cur_words_ff;
      src_word    = src_words[head_item.pos[POS_W-1:2]];
      rsp_byte_in = rsp_byte_ff;
      if (pop) begin
         rsp_byte_in = head_item.data ^ src_word[{head_item.pos[1:0], 3'b000} +: 8];
      end
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);

      cur_words_in = swap ? next_words_ff : cur_words_ff;

      // drop a stale prefetch, take a finished block
      next_words_in = next_words_ff;
      next_tag_in   = next_tag_ff;
      next_valid_in = next_valid_ff;
      if (cfg_write || eng_cmd.start) begin
         next_valid_in = 1'b0;
      end else if (eng_result.valid) begin
         next_valid_in = 1'b1;
         next_words_in = eng_result.words;
         next_tag_in   = eng_result.tag;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_valid_ff <= next_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_words_ff  <= cur_words_in;
      next_words_ff <= next_words_in;
      next_tag_ff   <= next_tag_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   a_new_block_ready: assert property (@(posedge clock) disable iff (reset)
      swap |-> hit)
      else $error("beat left with a block that is not ready");

   a_result_into_empty: assert property (@(posedge clock) disable iff (reset)
      eng_result.valid |-> !next_valid_ff)
      else $error("block result overwrote a held prefetch");

   a_cfg_drops_prefetch: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> !next_valid_ff)
      else $error("prefetched block survived a key change");

   a_no_pop_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("beat taken while the result register is held");

endmodule

`default_nettype wire

// ----- sv/chacha20_stream_cipher_core.sv -----
// A beat that needs no new block leaves through its queue slot and then the result register.
// A beat that opens a message, or whose block is not prefetched, waits for a block from the
// round engine (load, 40 half quarter-round steps of four lanes, feed-forward) plus the queue stages.
// Throughput: one byte per cycle unless stalled; the next block is computed as this one streams out.
// Reset: synchronous, clears position, counter, queue, prefetch and configuration registers.
`default_nettype none

module chacha20_stream_cipher_core #(
   parameter int QUEUE_DEPTH = cc20sc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_message_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [7:0]                              rsp_out_byte,
   input  wire logic                               csr_write,
   input  wire logic [cc20sc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cc20sc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cc20sc_pkg::*;

   logic [3:0][CSR_DATA_W-1:0] key_ff;
   logic [CSR_DATA_W-1:0]      nonce_low_ff;
   logic [WORD_W-1:0]          nonce_high_ff;
   logic [WORD_W-1:0]          init_ctr_ff;
   cipher_cfg_type             cfg;

   logic                       push;
   logic                       full;
   logic                       pop;
   logic                       head_valid;
   queue_item_type             push_item;
   queue_item_type             head_item;
   engine_cmd_type             eng_cmd;
   engine_status_type          eng_status;
   engine_result_type          eng_result;

   // take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         init_ctr_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_PART0:       key_ff[0]     <= csr_data;
            CSR_KEY_PART1:       key_ff[1]     <= csr_data;
            CSR_KEY_PART2:       key_ff[2]     <= csr_data;
            CSR_KEY_PART3:       key_ff[3]     <= csr_data;
            CSR_NONCE_LOW:       nonce_low_ff  <= csr_data;
            CSR_NONCE_HIGH:      nonce_high_ff <= csr_data[WORD_W-1:0];
            CSR_INITIAL_COUNTER: init_ctr_ff   <= csr_data[WORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // key and nonce as little-endian words
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cfg.key[2*k]     = key_ff[k][WORD_W-1:0];
         cfg.key[2*k + 1] = key_ff[k][CSR_DATA_W-1:WORD_W];
      end
      cfg.nonce[0] = nonce_low_ff[WORD_W-1:0];
      cfg.nonce[1] = nonce_low_ff[CSR_DATA_W-1:WORD_W];
      cfg.nonce[2] = nonce_high_ff;
   end

   assign req_stall = full;

   cc20sc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_data_byte     (req_data_byte),
      .req_message_start (req_message_start),
      .initial_counter   (init_ctr_ff),
      .full              (full),
      .push              (push),
      .item              (push_item)
   );

   cc20sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   cc20sc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .cmd    (eng_cmd),
      .status (eng_status),
      .result (eng_result)
   );

   cc20sc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg_write    (csr_write),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .pop          (pop),
      .eng_cmd      (eng_cmd),
      .eng_status   (eng_status),
      .eng_result   (eng_result),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

`default_nettype wire

// ----- tb/tb_chacha20_stream_cipher_core.sv -----
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher_core;

   localparam int BYTE_TARGET  = 650;
   localparam int SETTLE_TICKS = 64;
   // index 7 is outside the register map and must be ignored
   localparam logic [cc20sc_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;
   // "expand 32-byte k"
   localparam logic [31:0] EXPAND_W0 = 32'h6170_7865;
   localparam logic [31:0] EXPAND_W1 = 32'h3320_646e;
   localparam logic [31:0] EXPAND_W2 = 32'h7962_2d32;
   localparam logic [31:0] EXPAND_W3 = 32'h6b20_6574;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } byte_beat_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [7:0]                         req_data_byte;
   logic                               req_message_start;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [7:0]                         rsp_out_byte;
   logic                               csr_write;
   logic [cc20sc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cc20sc_pkg::CSR_DATA_W-1:0]  csr_data;

   // cipher model state
   logic [63:0]             key_dw [4];
   logic [63:0]             nonce_lo;
   logic [31:0]             nonce_hi;
   logic [31:0]             counter_start;
   cc20sc_pkg::block_type   keystream;
   logic [5:0]              stream_pos;
   logic [31:0]             stream_counter;

   byte_beat_type pending_beats [$];
   logic [7:0]    expected_bytes [$];
   byte_beat_type beat_out;
   int            send_gap;
   int            stall_run;
   bit            idle_on;
   int            mismatches;
   int            bytes_queued;
   int            bytes_taken;
   int            bytes_checked;
   int            messages_seen;
   int            blocks_made;
   int            settings_loaded;

   chacha20_stream_cipher_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // one quarter round on four words
   function automatic logic [127:0] quarter(input logic [31:0] a, b, c, d);
      a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
      c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
      a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
      c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
      return {a, b, c, d};
   endfunction

   // twenty rounds plus feed-forward for one block counter
   function automatic cc20sc_pkg::block_type chacha_block(input logic [31:0] ctr);
      logic [31:0]           init_w [16];
      logic [31:0]           x [16];
      logic [127:0]          q;
      cc20sc_pkg::block_type blk;
      int                    ia, ib, ic, id;
      init_w[0]  = EXPAND_W0;          init_w[1]  = EXPAND_W1;
      init_w[2]  = EXPAND_W2;          init_w[3]  = EXPAND_W3;
      init_w[4]  = key_dw[0][31:0];    init_w[5]  = key_dw[0][63:32];
      init_w[6]  = key_dw[1][31:0];    init_w[7]  = key_dw[1][63:32];
      init_w[8]  = key_dw[2][31:0];    init_w[9]  = key_dw[2][63:32];
      init_w[10] = key_dw[3][31:0];    init_w[11] = key_dw[3][63:32];
      init_w[12] = ctr;
      init_w[13] = nonce_lo[31:0];     init_w[14] = nonce_lo[63:32];
      init_w[15] = nonce_hi;
      x = init_w;
      for (int r = 0; r < 10; r++) begin
         // columns first, then diagonals
         for (int k = 0; k < 8; k++) begin
            ia = k % 4;
            if (k < 4) begin
               ib = 4 + ia; ic = 8 + ia; id = 12 + ia;
            end else begin
               ib = 4 + (ia + 1) % 4; ic = 8 + (ia + 2) % 4; id = 12 + (ia + 3) % 4;
            end
            q = quarter(x[ia], x[ib], x[ic], x[id]);
            {x[ia], x[ib], x[ic], x[id]} = q;
         end
      end
      for (int i = 0; i < 16; i++) blk[i] = x[i] + init_w[i];
      return blk;
   endfunction

   // transform one byte and advance the stream position
   function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic start);
      logic [31:0] ks_word;
      if (start) begin
         stream_counter = counter_start;
         stream_pos     = '0;
         messages_seen++;
      end
      if (stream_pos == 6'd0) begin
         keystream      = chacha_block(stream_counter);
         stream_counter = stream_counter + 32'd1;
         blocks_made++;
      end
      ks_word    = keystream[stream_pos[5:2]] >> {stream_pos[1:0], 3'b000};
      stream_pos = stream_pos + 6'd1;
      return data ^ ks_word[7:0];
   endfunction

   function automatic void apply_reg(input logic [cc20sc_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [63:0] value);
      case (idx)
         cc20sc_pkg::CSR_KEY_PART0:       key_dw[0] = value;
         cc20sc_pkg::CSR_KEY_PART1:       key_dw[1] = value;
         cc20sc_pkg::CSR_KEY_PART2:       key_dw[2] = value;
         cc20sc_pkg::CSR_KEY_PART3:       key_dw[3] = value;
         cc20sc_pkg::CSR_NONCE_LOW:       nonce_lo = value;
         cc20sc_pkg::CSR_NONCE_HIGH:      nonce_hi = value[31:0];
         cc20sc_pkg::CSR_INITIAL_COUNTER: counter_start = value[31:0];
         default: ;
      endcase
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic log_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, what);
   endtask

   task automatic write_reg(input logic [cc20sc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      apply_reg(idx, value);
      @(negedge clock);
   endtask

   // write every register: 0 random, 1 all zero, 2 all ones
   task automatic load_settings(input int flavour);
      logic [63:0] value;
      for (int i = 0; i <= int'(cc20sc_pkg::CSR_INITIAL_COUNTER); i++) begin
         case (flavour)
            1:       value = '0;
            2:       value = '1;
            default: value = {$urandom, $urandom};
         endcase
         // bias the start counter towards the wrap now and then
         if (flavour == 0 && i == int'(cc20sc_pkg::CSR_INITIAL_COUNTER) &&
             $urandom_range(0, 2) == 0)
            value = 64'hFFFF_FFFF - $urandom_range(0, 2);
         write_reg(i[cc20sc_pkg::CSR_INDEX_W-1:0], value);
      end
      if ($urandom_range(0, 1) == 0) write_reg(CSR_UNMAPPED, {$urandom, $urandom});
      settings_loaded++;
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic start);
      byte_beat_type b;
      b.data  = data;
      b.start = start;
      pending_beats.push_back(b);
      bytes_queued++;
   endtask

   // hold until every beat is out, then let the prefetch settle
   task automatic settle();
      while (pending_beats.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // drive request beats, predicting each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_bytes.push_back(cipher_byte(req_data_byte, req_message_start));
            bytes_taken++;
         end
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_beats.size() != 0) begin
            beat_out = pending_beats.pop_front();
            req_data_byte     <= beat_out.data;
            req_message_start <= beat_out.start;
            req_valid         <= 1'b1;
            send_gap = idle_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // check response beats and stall the response side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               log_mismatch($sformatf("unexpected byte 0x%02h", rsp_out_byte));
            end else begin
               if (rsp_out_byte !== expected_bytes[0])
                  log_mismatch($sformatf("byte %0d: out 0x%02h, expected 0x%02h",
                                         bytes_checked, rsp_out_byte, expected_bytes[0]));
               void'(expected_bytes.pop_front());
            end
            bytes_checked++;
         end
         if (stall_run != 0) begin
            stall_run--;
         end else if (idle_on && pick_gap() != 0) begin
            rsp_stall <= 1'b1;
            stall_run = pick_gap();
         end else begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(0, 6);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [7:0] opening [6];
      int         sel;
      int         len;
      int         drain_ticks;
      bit         opener;
      bit         first_round;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_message_start = 1'b0;
      rsp_stall         = 1'b0;
      csr_write         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      idle_on           = 1'b1;
      mismatches        = 0;
      bytes_queued      = 0;
      bytes_taken       = 0;
      bytes_checked     = 0;
      messages_seen     = 0;
      blocks_made       = 0;
      settings_loaded   = 0;
      key_dw            = '{default: '0};
      nonce_lo          = '0;
      nonce_hi          = '0;
      counter_start     = '0;
      keystream         = '0;
      stream_pos        = '0;
      stream_counter    = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // stream with no message start after reset: zero key, counter 0
      opening = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
      foreach (opening[i]) queue_byte(opening[i], 1'b0);
      settle();

      // all-ones settings, back-to-back message starts
      load_settings(2);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h3C, 1'b0);
      queue_byte(8'hC3, 1'b1);
      queue_byte(8'h7E, 1'b0);
      settle();

      // key and start counter change mid-message: the block in use stays
      write_reg(cc20sc_pkg::CSR_KEY_PART0, {$urandom, $urandom});
      write_reg(cc20sc_pkg::CSR_INITIAL_COUNTER, 64'd5);
      for (int i = 0; i < 4; i++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      settle();

      // random rounds of settings and messages
      first_round = 1'b1;
      while (bytes_queued < BYTE_TARGET) begin
         sel = $urandom_range(0, 9);
         if (first_round) begin
            load_settings(0);
            write_reg(cc20sc_pkg::CSR_INITIAL_COUNTER, 64'hFFFF_FFFF);
         end else if (sel < 6) begin
            load_settings(0);
         end else if (sel == 6) begin
            load_settings(1);
         end else if (sel == 7) begin
            load_settings(2);
         end
         idle_on = ($urandom_range(0, 3) != 0);
         for (int m = $urandom_range(1, 4); m > 0 && bytes_queued < BYTE_TARGET; m--) begin
            if (first_round) len = 130;
            else if ($urandom_range(0, 4) == 0) len = $urandom_range(60, 140);
            else len = $urandom_range(1, 24);
            if (len > BYTE_TARGET - bytes_queued) len = BYTE_TARGET - bytes_queued;
            // now and then carry on the previous stream instead of opening a message
            opener = first_round || ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++)
               queue_byte(8'($urandom_range(0, 255)),
                          (i == 0 && opener) || ($urandom_range(0, 99) == 0));
            first_round = 1'b0;
         end
         settle();
      end

      // final drain with a bound on the wait for outstanding bytes
      while (pending_beats.size() != 0 || req_valid) @(negedge clock);
      drain_ticks = 0;
      while (expected_bytes.size() != 0 && drain_ticks < 5000) begin
         @(negedge clock);
         drain_ticks++;
      end
      repeat (SETTLE_TICKS) @(negedge clock);
      if (expected_bytes.size() != 0)
         log_mismatch($sformatf("%0d bytes never returned", expected_bytes.size()));

      $display("Ran %0d bytes in %0d messages, %0d keystream blocks, %0d register sets",
               bytes_taken, messages_seen, blocks_made, settings_loaded);
      $display("Checked %0d response bytes, %0d mismatches", bytes_checked, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
